// ===== design/maf_pkg.sv =====
// Shared types, sizes and fixed-point helpers for the multiplicative
// activation forward block. No dependencies.
package maf_pkg;

    localparam int MAX_FEATURES = 16;
    localparam int MAX_UNITS    = 8;
    localparam int FEAT_W       = $clog2(MAX_FEATURES);
    localparam int UNIT_W       = $clog2(MAX_UNITS);
    localparam int WADDR_W      = FEAT_W + UNIT_W;
    localparam int NF_W         = 5;
    localparam int NU_W         = 4;
    localparam int DATA_W       = 32;
    localparam int WIDE_W       = 66;
    localparam int FRAC_W       = 24;

    localparam logic [NF_W-1:0] NF_RESET = NF_W'(16);
    localparam logic [NU_W-1:0] NU_RESET = NU_W'(8);
    localparam logic [NF_W-1:0] NF_MAX   = NF_W'(MAX_FEATURES);
    localparam logic [NU_W-1:0] NU_MAX   = NU_W'(MAX_UNITS);

    localparam logic signed [WIDE_W-1:0] Q_ONE_WIDE = 66'sd16777216;
    localparam logic signed [WIDE_W-1:0] Q_HALF     = 66'sd8388608;
    localparam logic signed [DATA_W-1:0] Q_ONE      = 32'sd16777216;
    localparam logic signed [DATA_W-1:0] S32_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN    = 32'sh8000_0000;

    // Register indexes on the configuration port.
    localparam logic REG_FEATURES = 1'b0;
    localparam logic REG_UNITS    = 1'b1;

    typedef struct packed {
        logic [NF_W-1:0] nf;
        logic [NU_W-1:0] nu;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prod;
        logic                     mark;
    } prod_entry_t;

    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] unit;
    } issue_t;

    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] unit;
        prod_entry_t       data;
    } wb_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } rs_t;

    // Q16.48 to Q8.24 with round half up, then saturation to 32 bits.
    function automatic rs_t round_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        logic [WIDE_W-FRAC_W-1:0] q;
        logic                     fits;
        rs_t                      res;
        r    = v + Q_HALF;
        q    = r[WIDE_W-1:FRAC_W];
        fits = (&q[WIDE_W-FRAC_W-1:DATA_W-1]) || !(|q[WIDE_W-FRAC_W-1:DATA_W-1]);
        if (fits)
        begin
            res.val = q[DATA_W-1:0];
            res.sat = 1'b0;
        end
        else
        begin
            res.val = q[WIDE_W-FRAC_W-1] ? S32_MIN : S32_MAX;
            res.sat = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== design/maf_in_if.sv =====
// Input channel of the multiplicative activation block: weight writes and
// feature samples. Depends on maf_pkg.
interface maf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic [3:0]                            feature_index;
    logic [2:0]                            unit_index;
    logic signed [maf_pkg::DATA_W-1:0]     value;

    modport source (output valid, op, feature_index, unit_index, value, input ready);
    modport sink   (input valid, op, feature_index, unit_index, value, output ready);
endinterface

// ===== design/maf_out_if.sv =====
// Result channel of the multiplicative activation block: one row product
// per unit. Depends on maf_pkg.
interface maf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            unit_number;
    logic signed [maf_pkg::DATA_W-1:0]     product;
    logic                                  saturated;
    logic                                  last;

    modport source (output valid, unit_number, product, saturated, last, input ready);
    modport sink   (input valid, unit_number, product, saturated, last, output ready);
endinterface

// ===== design/multiplicative_activation_forward.sv =====
// Multiplicative activation layer, forward pass: top level with sequencer.
// Depends on maf_pkg, maf_in_if, maf_out_if, maf_cfg, maf_wmem, maf_pmem, maf_term.
//
// Usage. The samples channel takes two kinds of transfer: op 0 writes one
// Q8.24 weight at (feature_index, unit_index), op 1 brings the next feature
// value of the current row. A feature sample reads one weight and one
// running product per active unit from the two memories, one unit per
// cycle, through a four-stage multiply pipeline and writes the products
// back. Samples are taken one at a time; ready is low while a sample or a
// row output is in work. After features_in_use samples the results channel
// carries one transfer per active unit, in unit order, with last on the
// final one, and a stalled result holds until it is taken. The products
// then read as 1.0 again and the next row starts.
// Reset clears the sequencer, feature count, product valid bits and sets
// the registers to 16 features and 8 units; weights are unknown until written.
module multiplicative_activation_forward (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    maf_in_if.sink           samples,
    maf_out_if.source        results
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ERD   = 3'd3;
    localparam logic [2:0] S_ELD   = 3'd4;
    localparam logic [2:0] S_EWT   = 3'd5;

    maf_pkg::cfg_t                     cfg;
    logic [2:0]                        state_reg, state_next;
    logic [maf_pkg::FEAT_W-1:0]        fcnt_reg, fcnt_next;
    logic [maf_pkg::UNIT_W-1:0]        ucnt_reg, ucnt_next;
    logic signed [maf_pkg::DATA_W-1:0] x_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [maf_pkg::UNIT_W-1:0]        out_unit_reg;
    logic signed [maf_pkg::DATA_W-1:0] out_prod_reg;
    logic                              out_sat_reg;
    logic                              out_last_reg;
    logic                              accept;
    logic                              w_we;
    logic                              clear;
    logic                              last_unit;
    logic                              row_end;
    logic                              busy;
    logic signed [maf_pkg::DATA_W-1:0] w_rdata;
    maf_pkg::prod_entry_t              p_rdata;
    maf_pkg::issue_t                   issue;
    maf_pkg::wb_t                      wb;

    maf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign w_we          = accept && !samples.op;

    maf_wmem u_wmem (
        .clk   (clk),
        .we    (w_we),
        .waddr ({samples.feature_index, samples.unit_index}),
        .wdata (samples.value),
        .raddr ({fcnt_reg, ucnt_reg}),
        .rdata (w_rdata)
    );

    maf_pmem u_pmem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .wb    (wb),
        .raddr (ucnt_reg),
        .rdata (p_rdata)
    );

    assign issue.valid = (state_reg == S_RUN);
    assign issue.unit  = ucnt_reg;

    maf_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .x     (x_reg),
        .w     (w_rdata),
        .run   (p_rdata),
        .wb    (wb),
        .busy  (busy)
    );

    assign last_unit = ({1'b0, ucnt_reg} == (cfg.nu - maf_pkg::NU_W'(1)));
    assign row_end   = ({1'b0, fcnt_reg} + maf_pkg::NF_W'(1)) >= cfg.nf;

    always_comb
    begin
        state_next     = state_reg;
        fcnt_next      = fcnt_reg;
        ucnt_next      = ucnt_reg;
        out_valid_next = out_valid_reg;
        clear          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ucnt_next = '0;
                if (accept && samples.op)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (last_unit)
                    state_next = S_DRAIN;
                else
                    ucnt_next = ucnt_reg + maf_pkg::UNIT_W'(1);
            end
            S_DRAIN:
            begin
                // Wait for the last write-back before the next sample or the output.
                ucnt_next = '0;
                if (!busy)
                begin
                    fcnt_next  = fcnt_reg + maf_pkg::FEAT_W'(1);
                    state_next = row_end ? S_ERD : S_IDLE;
                end
            end
            S_ERD:
            begin
                state_next = S_ELD;
            end
            S_ELD:
            begin
                out_valid_next = 1'b1;
                state_next     = S_EWT;
            end
            S_EWT:
            begin
                if (results.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        clear      = 1'b1;
                        fcnt_next  = '0;
                        ucnt_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ucnt_next  = ucnt_reg + maf_pkg::UNIT_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcnt_reg      <= '0;
            ucnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            ucnt_reg      <= ucnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && samples.op)
            x_reg <= samples.value;
        if (state_reg == S_ELD)
        begin
            out_unit_reg <= ucnt_reg;
            out_prod_reg <= p_rdata.prod;
            out_sat_reg  <= p_rdata.mark;
            out_last_reg <= last_unit;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.unit_number = out_unit_reg;
    assign results.product     = out_prod_reg;
    assign results.saturated   = out_sat_reg;
    assign results.last        = out_last_reg;

endmodule

// ===== design/maf_cfg.sv =====
// APB-style register file holding the feature and unit counts.
// Depends on maf_pkg.
module maf_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output maf_pkg::cfg_t                cfg
);

    logic [maf_pkg::NF_W-1:0] nf_reg;
    logic [maf_pkg::NU_W-1:0] nu_reg;
    logic                     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg <= maf_pkg::NF_RESET;
            nu_reg <= maf_pkg::NU_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                maf_pkg::REG_FEATURES: nf_reg <= pwdata[maf_pkg::NF_W-1:0];
                maf_pkg::REG_UNITS:    nu_reg <= pwdata[maf_pkg::NU_W-1:0];
                default:               nf_reg <= nf_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            maf_pkg::REG_FEATURES: prdata = 32'(nf_reg);
            maf_pkg::REG_UNITS:    prdata = 32'(nu_reg);
            default:               prdata = '0;
        endcase
    end

    // A count of zero behaves as one; counts above the store size are capped.
    always_comb
    begin
        if (nf_reg == '0)
            cfg.nf = maf_pkg::NF_W'(1);
        else if (nf_reg > maf_pkg::NF_MAX)
            cfg.nf = maf_pkg::NF_MAX;
        else
            cfg.nf = nf_reg;

        if (nu_reg == '0)
            cfg.nu = maf_pkg::NU_W'(1);
        else if (nu_reg > maf_pkg::NU_MAX)
            cfg.nu = maf_pkg::NU_MAX;
        else
            cfg.nu = nu_reg;
    end

endmodule

// ===== design/maf_wmem.sv =====
// Weight store: one Q8.24 weight per (feature, unit), synchronous read.
// Depends on maf_pkg.
module maf_wmem (
    input  logic                              clk,
    input  logic                              we,
    input  logic [maf_pkg::WADDR_W-1:0]       waddr,
    input  logic signed [maf_pkg::DATA_W-1:0] wdata,
    input  logic [maf_pkg::WADDR_W-1:0]       raddr,
    output logic signed [maf_pkg::DATA_W-1:0] rdata
);

    localparam int DEPTH = maf_pkg::MAX_FEATURES * maf_pkg::MAX_UNITS;

    logic signed [maf_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [maf_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/maf_pmem.sv =====
// Running-product store: product and saturation mark per unit, synchronous
// read, with per-entry valid bits so that a cleared entry reads as 1.0.
// Depends on maf_pkg.
module maf_pmem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  maf_pkg::wb_t                      wb,
    input  logic [maf_pkg::UNIT_W-1:0]        raddr,
    output maf_pkg::prod_entry_t              rdata
);

    maf_pkg::prod_entry_t           mem [maf_pkg::MAX_UNITS];
    maf_pkg::prod_entry_t           mem_q_reg;
    logic [maf_pkg::MAX_UNITS-1:0]  valid_reg;
    logic                           valid_q_reg;

    always_ff @(posedge clk)
    begin
        if (wb.valid)
            mem[wb.unit] <= wb.data;
        mem_q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            valid_q_reg <= valid_reg[raddr];
            if (clear)
                valid_reg <= '0;
            else if (wb.valid)
                valid_reg[wb.unit] <= 1'b1;
        end
    end

    always_comb
    begin
        if (valid_q_reg)
            rdata = mem_q_reg;
        else
        begin
            rdata.prod = maf_pkg::Q_ONE;
            rdata.mark = 1'b0;
        end
    end

endmodule

// ===== design/maf_term.sv =====
// Update pipeline for one unit: term = x*w + (1 - w), product = run * term,
// each rounded and saturated. Four register stages. Depends on maf_pkg.
module maf_term (
    input  logic                              clk,
    input  logic                              rst_n,
    input  maf_pkg::issue_t                   issue,
    input  logic signed [maf_pkg::DATA_W-1:0] x,
    input  logic signed [maf_pkg::DATA_W-1:0] w,
    input  maf_pkg::prod_entry_t              run,
    output maf_pkg::wb_t                      wb,
    output logic                              busy
);

    logic                              v0_reg, v1_reg, v2_reg, v3_reg;
    logic [maf_pkg::UNIT_W-1:0]        u0_reg, u1_reg, u2_reg, u3_reg;
    logic signed [63:0]                m1_reg;
    logic signed [maf_pkg::DATA_W-1:0] w1_reg;
    logic signed [maf_pkg::DATA_W-1:0] run1_reg, run2_reg;
    logic                              mark1_reg, mark2_reg, mark3_reg;
    logic signed [maf_pkg::DATA_W-1:0] t_reg;
    logic                              tsat_reg;
    logic signed [63:0]                m2_reg;
    logic signed [maf_pkg::WIDE_W-1:0] term_sum;
    logic signed [maf_pkg::WIDE_W-1:0] bias;
    maf_pkg::rs_t                      term_rs;
    maf_pkg::rs_t                      prod_rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Memory read data lines up with stage zero.
    always_comb
    begin
        bias     = (maf_pkg::Q_ONE_WIDE - maf_pkg::WIDE_W'(w1_reg)) <<< maf_pkg::FRAC_W;
        term_sum = maf_pkg::WIDE_W'(m1_reg) + bias;
        term_rs  = maf_pkg::round_sat(term_sum);
        prod_rs  = maf_pkg::round_sat(maf_pkg::WIDE_W'(m2_reg));
    end

    always_ff @(posedge clk)
    begin
        u0_reg    <= issue.unit;
        u1_reg    <= u0_reg;
        m1_reg    <= x * w;
        w1_reg    <= w;
        run1_reg  <= run.prod;
        mark1_reg <= run.mark;
        u2_reg    <= u1_reg;
        t_reg     <= term_rs.val;
        tsat_reg  <= term_rs.sat;
        run2_reg  <= run1_reg;
        mark2_reg <= mark1_reg;
        u3_reg    <= u2_reg;
        m2_reg    <= run2_reg * t_reg;
        mark3_reg <= mark2_reg | tsat_reg;
    end

    assign wb.valid     = v3_reg;
    assign wb.unit      = u3_reg;
    assign wb.data.prod = prod_rs.val;
    assign wb.data.mark = mark3_reg | prod_rs.sat;
    assign busy         = v0_reg | v1_reg | v2_reg | v3_reg;

endmodule

// ===== tb/maf_check_pkg.sv =====
// Expected-result tracking for the multiplicative activation forward test:
// transfer codes, the result record and the row product scoreboard.
// Depends on maf_pkg for sizes and register indexes.
package maf_check_pkg;
    import maf_pkg::*;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct {
        logic [2:0]         unit;
        logic signed [31:0] product;
        logic               saturated;
        logic               last;
    } unit_result_t;

    class activation_row_model;
        logic signed [31:0] weights [MAX_FEATURES][MAX_UNITS];
        bit                 weight_set [MAX_FEATURES][MAX_UNITS];
        logic signed [31:0] products [MAX_UNITS];
        bit                 marks [MAX_UNITS];
        int                 fcount;
        logic [4:0]         nf_reg;
        logic [3:0]         nu_reg;
        unit_result_t       awaiting_products [$];
        int                 errors;

        function new();
            nf_reg       = 5'd16;
            nu_reg       = 4'd8;
            errors       = 0;
            clear_row();
        endfunction

        function void clear_row();
            for (int u = 0; u < MAX_UNITS; u++)
            begin
                products[u] = 32'sh0100_0000;
                marks[u]    = 1'b0;
            end
            fcount = 0;
        endfunction

        function int feature_limit();
            if (nf_reg == 0)
                return 1;
            return (nf_reg > MAX_FEATURES) ? MAX_FEATURES : int'(nf_reg);
        endfunction

        function int active_units();
            if (nu_reg == 0)
                return 1;
            return (nu_reg > MAX_UNITS) ? MAX_UNITS : int'(nu_reg);
        endfunction

        function int awaiting();
            return awaiting_products.size();
        endfunction

        function bit weight_known(int feature, int unit);
            return weight_set[feature][unit];
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == REG_FEATURES)
                nf_reg = data[4:0];
            else
                nu_reg = data[3:0];
        endfunction

        // Round half up from Q16.48 to Q8.24, then clip to 32 bits.
        function logic signed [31:0] round_clip(logic signed [65:0] v, inout bit flag);
            logic signed [65:0] r;
            r = (v + 66'sd8388608) >>> 24;
            if (r > 66'sd2147483647)
            begin
                flag = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (r < -66'sd2147483648)
            begin
                flag = 1'b1;
                return 32'sh8000_0000;
            end
            return r[31:0];
        endfunction

        function void apply_item(logic op, logic [3:0] fi, logic [2:0] ui,
                                 logic signed [31:0] x);
            logic signed [65:0] xw;
            logic signed [65:0] ww;
            logic signed [65:0] acc;
            logic signed [31:0] term;
            bit                 flag;
            unit_result_t       r;
            int                 units;
            units = active_units();
            if (op == OP_WEIGHT)
            begin
                weights[fi][ui]    = x;
                weight_set[fi][ui] = 1'b1;
                return;
            end
            if (fcount < MAX_FEATURES)
            begin
                for (int u = 0; u < units; u++)
                begin
                    xw   = x;
                    ww   = weights[fcount][u];
                    flag = 1'b0;
                    term = round_clip(xw * ww + ((66'sd16777216 - ww) <<< 24), flag);
                    acc  = products[u];
                    ww   = term;
                    products[u] = round_clip(acc * ww, flag);
                    if (flag)
                        marks[u] = 1'b1;
                end
            end
            fcount++;
            // The row closes once the count reaches or passes the current setting.
            if (fcount >= feature_limit())
            begin
                for (int u = 0; u < units; u++)
                begin
                    r.unit      = u[2:0];
                    r.product   = products[u];
                    r.saturated = marks[u];
                    r.last      = (u + 1 == units);
                    awaiting_products.push_back(r);
                end
                clear_row();
            end
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void match_result(logic [2:0] unit, logic signed [31:0] product,
                                   logic saturated, logic last);
            unit_result_t e;
            if (awaiting_products.size() == 0)
            begin
                errors++;
                $display("%t: unexpected result, expected none, actual unit %0d %h sat %b last %b",
                         $time, unit, product, saturated, last);
                return;
            end
            e = awaiting_products.pop_front();
            report_field("unit_number", e.unit, unit);
            report_field("product", e.product, product);
            report_field("saturated", e.saturated, saturated);
            report_field("last", e.last, last);
        endfunction
    endclass

endpackage

// ===== tb/multiplicative_activation_forward_test.sv =====
// Self-checking test of multiplicative_activation_forward: directed corner
// rows, then random rows under random idling and back-pressure.
// Depends on the design, maf_pkg, maf_in_if, maf_out_if and maf_check_pkg.
module multiplicative_activation_forward_test;
    timeunit 1ns;
    timeprecision 1ps;

    import maf_pkg::*;
    import maf_check_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 75;

    localparam logic signed [31:0] Q_UNIT = 32'sh0100_0000;
    localparam logic signed [31:0] EDGE_VALUES [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0100_0000,
        32'shFF00_0000, 32'sh0000_0001, 32'sh0080_0000, 32'shFFFF_FFFF
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    maf_in_if  samples_ch ();
    maf_out_if results_ch ();

    multiplicative_activation_forward dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_ch),
        .results (results_ch)
    );

    activation_row_model board = new();

    int cycles = 0;
    int burst_left = 0;
    int items_sent = 0;
    int hold_requests = 0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            4, 5: return Q_UNIT + int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    // One transfer on the samples channel; the sender then keeps going or
    // drops valid for a gap at the end of its burst.
    task automatic send_item(input logic op, input logic [3:0] fi, input logic [2:0] ui,
                             input logic signed [31:0] x);
        samples_ch.valid         <= 1'b1;
        samples_ch.op            <= op;
        samples_ch.feature_index <= fi;
        samples_ch.unit_index    <= ui;
        samples_ch.value         <= x;
        do
            @(posedge clk);
        while (samples_ch.ready !== 1'b1);
        board.apply_item(op, fi, ui, x);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            samples_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // A sample never reads an unwritten weight, so missing ones go in first.
    task automatic send_sample(input logic signed [31:0] x);
        int feature;
        feature = board.fcount;
        for (int u = 0; u < board.active_units(); u++)
            if (!board.weight_known(feature, u))
                send_item(OP_WEIGHT, feature[3:0], u[2:0], pick_value());
        send_item(OP_SAMPLE, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), x);
    endtask

    task automatic drain_and_settle();
        samples_ch.valid <= 1'b0;
        while (board.awaiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic idx, input logic [31:0] data,
                                output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rd = prdata;
    endtask

    task automatic check_register(input logic idx, input logic [4:0] want);
        logic [31:0] rd;
        logic [4:0]  mask;
        mask = (idx == REG_FEATURES) ? 5'h1F : 5'h0F;
        apb_transfer(1'b0, idx, 32'd0, rd);
        if ((rd[4:0] & mask) !== (want & mask))
        begin
            board.errors++;
            $display("%t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, want & mask, rd[4:0] & mask);
        end
    endtask

    // Writes both registers, each followed by a readback.
    task automatic set_rows(input int nf, input int nu);
        logic [31:0] rd;
        apb_transfer(1'b1, REG_FEATURES, 32'(nf), rd);
        board.set_register(REG_FEATURES, 32'(nf));
        check_register(REG_FEATURES, 5'(nf));
        apb_transfer(1'b1, REG_UNITS, 32'(nu), rd);
        board.set_register(REG_UNITS, 32'(nu));
        check_register(REG_UNITS, 5'(nu));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: checks every transfer and stalls in changing patterns.
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        int holds_served;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        holds_served = 0;
        results_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
                board.match_result(results_ch.unit_number, results_ch.product,
                                   results_ch.saturated, results_ch.last);
            tick++;
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: results_ch.ready <= 1'b1;
                    1: results_ch.ready <= 1'($urandom_range(0, 1));
                    2: results_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: results_ch.ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    initial
    begin
        int first_item;
        int nf;
        int nu;
        int count;
        bit opening;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        samples_ch.valid         <= 1'b0;
        samples_ch.op            <= OP_WEIGHT;
        samples_ch.feature_index <= '0;
        samples_ch.unit_index    <= '0;
        samples_ch.value         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_register(REG_FEATURES, 5'd16);
        check_register(REG_UNITS, 5'd8);
        psel    <= 1'b0;
        penable <= 1'b0;
        drain_and_settle();

        // One-feature rows over the extreme weights and extreme samples.
        set_rows(1, 8);
        for (int u = 0; u < 8; u++)
            send_item(OP_WEIGHT, 4'd0, u[2:0], EDGE_VALUES[u]);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0000);
        send_sample(Q_UNIT);
        send_item(OP_WEIGHT, 4'd15, 3'd7, pick_value());

        // Zero in either register behaves as one.
        drain_and_settle();
        set_rows(0, 0);
        send_sample(32'sh0000_0001);

        // Oversized unit count behaves as the maximum.
        drain_and_settle();
        set_rows(1, 15);
        send_sample(-Q_UNIT);

        // Shorten the row after three samples; the next one closes it.
        drain_and_settle();
        set_rows(31, 2);
        repeat (3) send_sample(pick_value());
        drain_and_settle();
        set_rows(2, 2);
        send_sample(pick_value());

        first_item = items_sent;
        opening = 1'b1;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            drain_and_settle();
            if (opening)
            begin
                nf = 1;
                nu = 8;
                count = 24;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: nf = 0;
                    1: nf = $urandom_range(17, 31);
                    2: nf = 16;
                    default: nf = $urandom_range(1, 4);
                endcase
                case ($urandom_range(0, 9))
                    0: nu = 0;
                    1: nu = $urandom_range(9, 15);
                    2: nu = 8;
                    default: nu = $urandom_range(1, 8);
                endcase
                count = $urandom_range(6, 30);
            end
            set_rows(nf, nu);
            // The receiver holds off while the sender keeps pushing full rows.
            if (opening)
                hold_requests++;
            opening = 1'b0;
            repeat (count)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_item(OP_WEIGHT, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                              pick_value());
                else
                    send_sample(pick_value());
            end
        end

        drain_and_settle();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/maf_pkg.sv
design/maf_in_if.sv
design/maf_out_if.sv
design/maf_cfg.sv
design/maf_wmem.sv
design/maf_pmem.sv
design/maf_term.sv
design/multiplicative_activation_forward.sv
tb/maf_check_pkg.sv
tb/multiplicative_activation_forward_test.sv
